/* rtl/core/tepq_pkg.sv */
// Shared types and constants for the timed event priority queue.
package tepq_pkg;

    localparam int CAPACITY  = 16;
    localparam int TIME_BITS = 48;
    localparam int TAG_BITS  = 32;
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [TIME_BITS-1:0] time_val;
        logic [TAG_BITS-1:0]  tag;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

/* rtl/core/tepq_if.sv */
// Command and result channel interfaces of the timed event priority queue.
interface tepq_cmd_if;
    import tepq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           operation;
    logic [TIME_BITS-1:0] event_time;
    logic [TAG_BITS-1:0]  event_tag;

    modport source (output valid, output operation, output event_time, output event_tag,
                    input ready);
    modport sink   (input valid, input operation, input event_time, input event_tag,
                    output ready);
endinterface

interface tepq_res_if;
    import tepq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] out_time;
    logic [TAG_BITS-1:0]  out_tag;
    logic [1:0]           status;
    logic [CNT_BITS-1:0]  entry_count;
    logic                 is_empty;

    modport source (output valid, output out_time, output out_tag, output status,
                    output entry_count, output is_empty, input ready);
    modport sink   (input valid, input out_time, input out_tag, input status,
                    input entry_count, input is_empty, output ready);
endinterface

/* rtl/core/tepq_cell.sv */
// One slot of the sorted event chain: keeps, inserts or shifts its entry.
module tepq_cell (
    input  logic                i_clk,
    input  tepq_pkg::t_cell_ctl i_ctl,
    input  tepq_pkg::t_entry    i_new,
    input  logic                i_occ,
    input  logic                i_prev_keep,
    input  tepq_pkg::t_entry    i_left,
    input  tepq_pkg::t_entry    i_right,
    output tepq_pkg::t_entry    o_data,
    output logic                o_keep
);
    import tepq_pkg::*;

    t_entry r_data;
    t_entry n_data;

    assign o_keep = i_occ && (r_data.time_val <= i_new.time_val);
    assign o_data = r_data;

    always_comb begin
        n_data = r_data;
        priority if (i_ctl.push) begin
            priority if (o_keep) begin
                n_data = r_data;
            end else if (i_prev_keep) begin
                n_data = i_new;
            end else begin
                n_data = i_left;
            end
        end else if (i_ctl.pop) begin
            n_data = i_right;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push || i_ctl.pop) begin
            r_data <= n_data;
        end
    end

endmodule

/* rtl/core/timed_event_priority_queue.sv */
// Top level of the timed event priority queue built on a sorted cell chain.
//
// Events live in a chain of CAPACITY cells kept sorted by timestamp, with equal
// timestamps in insertion order, so the earliest event always sits in the first
// cell. A push inserts the new event: every cell compares the new timestamp with its
// own and either holds, takes the new event or takes its left neighbor's. A pop
// shifts every cell one place toward the head; a peek reads the head.
// A new command is taken every cycle while the result register is free or being
// drained; throughput is set by the result channel handshake. Every command gives
// exactly one result with the entry count after the command. A push to a full
// store is dropped with status full; a pop or peek on an empty store reports
// status empty; time and tag read zero then.
module timed_event_priority_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tepq_cmd_if.sink   i_cmd,
    tepq_res_if.source o_res
);
    import tepq_pkg::*;

    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;
    logic                r_res_valid;
    logic [TIME_BITS-1:0] r_res_time;
    logic [TAG_BITS-1:0]  r_res_tag;
    t_status             r_res_status;
    logic [CNT_BITS-1:0] r_res_count;

    logic      cmd_fire;
    t_op       op;
    logic      full;
    logic      empty;
    t_cell_ctl ctl;
    t_entry    new_entry;
    t_entry    cell_data [CAPACITY];
    logic      cell_keep [CAPACITY];
    logic      cell_occ  [CAPACITY];
    t_status   res_status;
    logic      take_head;

    assign i_cmd.ready = i_rst_n && (!r_res_valid || o_res.ready);
    assign cmd_fire    = i_cmd.valid && i_cmd.ready;
    assign op          = t_op'(i_cmd.operation);
    assign full        = (r_count == CNT_BITS'(CAPACITY));
    assign empty       = (r_count == '0);

    assign new_entry.time_val = i_cmd.event_time;
    assign new_entry.tag      = i_cmd.event_tag;

    assign ctl.push = cmd_fire && (op == OP_PUSH) && !full;
    assign ctl.pop  = cmd_fire && (op == OP_POP) && !empty;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        localparam logic [CNT_BITS-1:0] IDX = CNT_BITS'(gi);
        t_entry left_data;
        t_entry right_data;
        logic   prev_keep;

        assign cell_occ[gi] = IDX < r_count;

        if (gi == 0) begin : g_head
            assign left_data = new_entry;
            assign prev_keep = 1'b1;
        end else begin : g_body
            assign left_data = cell_data[gi-1];
            assign prev_keep = cell_keep[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_tail
            assign right_data = '0;
        end else begin : g_mid
            assign right_data = cell_data[gi+1];
        end

        tepq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_new       (new_entry),
            .i_occ       (cell_occ[gi]),
            .i_prev_keep (prev_keep),
            .i_left      (left_data),
            .i_right     (right_data),
            .o_data      (cell_data[gi]),
            .o_keep      (cell_keep[gi])
        );
    end

    always_comb begin
        n_count    = r_count;
        res_status = ST_OK;
        take_head  = 1'b0;
        unique case (op)
            OP_PUSH: begin
                if (full) begin
                    res_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_BITS'(1);
                end
            end
            OP_POP: begin
                if (empty) begin
                    res_status = ST_EMPTY;
                end else begin
                    take_head = 1'b1;
                    n_count   = r_count - CNT_BITS'(1);
                end
            end
            OP_PEEK: begin
                if (empty) begin
                    res_status = ST_EMPTY;
                end else begin
                    take_head = 1'b1;
                end
            end
            OP_NOP: begin
                res_status = ST_OK;
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (cmd_fire) begin
                r_count     <= n_count;
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_fire) begin
            r_res_time   <= take_head ? cell_data[0].time_val : '0;
            r_res_tag    <= take_head ? cell_data[0].tag : '0;
            r_res_status <= res_status;
            r_res_count  <= n_count;
        end
    end

    assign o_res.valid       = r_res_valid;
    assign o_res.out_time    = r_res_time;
    assign o_res.out_tag     = r_res_tag;
    assign o_res.status      = r_res_status;
    assign o_res.entry_count = r_res_count;
    assign o_res.is_empty    = (r_res_count == '0);

endmodule
